// File: src/nsq_pkg.sv
// Shared widths, control word types and the microprogram of the Newton square root block.
`default_nettype none
package nsq_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int DATA_WIDTH     = 32;
  localparam int MAX_ITERATIONS = 64;

  localparam int ROOT_W = 24;
  localparam int TOL_W  = 31;

  // A positive input has DATA_WIDTH-1 magnitude bits; the dividend is that shifted up.
  localparam int NUM_W  = DATA_WIDTH - 1 + FRAC_BITS;
  localparam int DCNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
  localparam int EXT_W  = (NUM_W > ROOT_W) ? NUM_W : ROOT_W;
  localparam int CMP_W  = (NUM_W > TOL_W) ? NUM_W : TOL_W;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_SET_HIT,
    OP_PUBLISH
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_FIRE,
    C_TRIVIAL,
    C_GZERO,
    C_DIV_MORE,
    C_CONV,
    C_ITER_LEFT,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cnd;
    pc_t   target;
  } ctrl_t;

  // Datapath flags that the sequencer branches on.
  typedef struct packed {
    logic in_fire;
    logic trivial;
    logic gzero;
    logic div_more;
    logic conv;
    logic iter_left;
    logic out_busy;
  } status_t;

  localparam pc_t S_WAIT    = 4'd0;
  localparam pc_t S_CLASS   = 4'd1;
  localparam pc_t S_DIV0    = 4'd2;
  localparam pc_t S_DIVLOOP = 4'd3;
  localparam pc_t S_UPDATE  = 4'd4;
  localparam pc_t S_CONV    = 4'd5;
  localparam pc_t S_AGAIN   = 4'd6;
  localparam pc_t S_LIMIT   = 4'd7;
  localparam pc_t S_PUBLISH = 4'd8;
  localparam pc_t S_RETURN  = 4'd9;

  // Read-only microprogram: the jump is taken when the condition holds, else pc+1.
  function automatic ctrl_t rom_word(input pc_t pc);
    ctrl_t w;
    case (pc)
      S_WAIT:    w = '{op: OP_LOAD,     cnd: C_NOT_FIRE,  target: S_WAIT};
      S_CLASS:   w = '{op: OP_NOP,      cnd: C_TRIVIAL,   target: S_PUBLISH};
      S_DIV0:    w = '{op: OP_DIV_INIT, cnd: C_GZERO,     target: S_PUBLISH};
      S_DIVLOOP: w = '{op: OP_DIV_STEP, cnd: C_DIV_MORE,  target: S_DIVLOOP};
      S_UPDATE:  w = '{op: OP_UPDATE,   cnd: C_NEVER,     target: S_WAIT};
      S_CONV:    w = '{op: OP_NOP,      cnd: C_CONV,      target: S_PUBLISH};
      S_AGAIN:   w = '{op: OP_NOP,      cnd: C_ITER_LEFT, target: S_DIV0};
      S_LIMIT:   w = '{op: OP_SET_HIT,  cnd: C_NEVER,     target: S_WAIT};
      S_PUBLISH: w = '{op: OP_PUBLISH,  cnd: C_OUT_BUSY,  target: S_PUBLISH};
      S_RETURN:  w = '{op: OP_NOP,      cnd: C_ALWAYS,    target: S_WAIT};
      default:   w = '{op: OP_NOP,      cnd: C_ALWAYS,    target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: src/nsq_in_if.sv
// Input channel interface carrying one signed fixed-point value per transaction.
`default_nettype none
interface nsq_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [nsq_pkg::DATA_WIDTH-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// File: src/nsq_out_if.sv
// Result channel interface carrying the root and its status flags per transaction.
`default_nettype none
interface nsq_out_if;
  logic                        valid;
  logic                        ready;
  logic [nsq_pkg::ROOT_W-1:0]  root;
  logic                        invalid;
  logic                        hit_limit;

  modport source (output valid, output root, output invalid, output hit_limit, input ready);
  modport sink   (input valid, input root, input invalid, input hit_limit, output ready);
endinterface
`default_nettype wire

// File: src/newton_square_root.sv
// Top level: Newton square root of a signed Q16.16 value under microcode control.
// Negative, zero and one go from the classify step straight to publish; other inputs
//   repeat divide, update and convergence check until converged or at the 64-step cap.
// One transaction at a time: each Newton step runs the serial divider, then the update;
//   the next input is taken only after a result is loaded for output.
// Synchronous active-low reset idles the sequencer, empties the output and sets tolerance 1.
`default_nettype none
module newton_square_root (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [nsq_pkg::TOL_W-1:0]   cfg_wdata,
  nsq_in_if.sink                           in_ch,
  nsq_out_if.source                        out_ch
);

  localparam int NW = nsq_pkg::NUM_W;
  localparam int DW = nsq_pkg::DATA_WIDTH;
  localparam logic [DW-1:0] ONE_VAL = DW'(1) << nsq_pkg::FRAC_BITS;
  localparam logic [nsq_pkg::EXT_W-1:0] ROOT_MAX =
    nsq_pkg::EXT_W'({nsq_pkg::ROOT_W{1'b1}});

  nsq_pkg::ctrl_t   ctrl;
  nsq_pkg::status_t status;

  // Configuration.
  logic [nsq_pkg::TOL_W-1:0] tol_r;

  // Operand and iteration state.
  logic                          neg_r;
  logic                          trivial_r;
  logic [NW-1:0]                 num_r;
  logic [NW-1:0]                 guess_r;
  logic [nsq_pkg::ITER_W-1:0]    iter_r;
  logic                          conv_r;
  logic                          hit_r;

  // Restoring divider: quotient bits shift in while dividend bits shift out.
  logic [NW-1:0]                 rem_r;
  logic [NW-1:0]                 quo_r;
  logic [nsq_pkg::DCNT_W-1:0]    dcnt_r;

  // Output register.
  logic                          out_valid_r;
  logic [nsq_pkg::ROOT_W-1:0]    out_root_r;
  logic                          out_invalid_r;
  logic                          out_hit_r;

  logic          in_fire;
  logic          out_busy;
  logic          publish;
  logic [NW:0]   shifted;
  logic [NW+1:0] trial;
  logic [NW-1:0] guess_nxt;
  logic [NW-1:0] diff;
  logic [nsq_pkg::EXT_W-1:0] guess_ext;
  logic [nsq_pkg::ROOT_W-1:0] root_nxt;

  nsq_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  // The input is open only on the wait step of the program, and never during reset.
  assign in_ch.ready = rst_n && (ctrl.op == nsq_pkg::OP_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // The output register can take a new result when empty or being drained now.
  assign out_busy = out_valid_r && !out_ch.ready;
  assign publish  = (ctrl.op == nsq_pkg::OP_PUBLISH) && !out_busy;

  assign status.in_fire   = in_fire;
  assign status.trivial   = trivial_r;
  assign status.gzero     = (guess_r == '0);
  assign status.div_more  = (dcnt_r != nsq_pkg::DCNT_W'(NW - 1));
  assign status.conv      = conv_r;
  assign status.iter_left = (iter_r != nsq_pkg::ITER_W'(nsq_pkg::MAX_ITERATIONS));
  assign status.out_busy  = out_busy;

  // One divider step: bring down the next dividend bit and try to subtract the guess.
  assign shifted = {rem_r, quo_r[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, guess_r};

  // The average is formed without overflow from the halves and their shared low bit.
  assign guess_nxt = (guess_r >> 1) + (quo_r >> 1) + NW'(guess_r[0] & quo_r[0]);
  assign diff      = (guess_r > guess_nxt) ? (guess_r - guess_nxt) : (guess_nxt - guess_r);

  // A root that does not fit the result field saturates; a negative input returns zero.
  assign guess_ext = nsq_pkg::EXT_W'(guess_r);
  assign root_nxt  = neg_r ? '0 :
                     (guess_ext > ROOT_MAX) ? {nsq_pkg::ROOT_W{1'b1}} :
                     guess_ext[nsq_pkg::ROOT_W-1:0];

  // Control state: configuration and output occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= nsq_pkg::TOL_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (publish) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Datapath, driven by the opcode of the current control word.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      nsq_pkg::OP_LOAD: begin
        if (in_fire) begin
          neg_r     <= in_ch.value[DW-1];
          trivial_r <= in_ch.value[DW-1] || (in_ch.value == '0) ||
                       (in_ch.value == ONE_VAL);
          guess_r   <= NW'(in_ch.value[DW-2:0]);
          num_r     <= NW'(in_ch.value[DW-2:0]) << nsq_pkg::FRAC_BITS;
          iter_r    <= '0;
          hit_r     <= 1'b0;
          conv_r    <= 1'b0;
        end
      end
      nsq_pkg::OP_DIV_INIT: begin
        rem_r  <= '0;
        quo_r  <= num_r;
        dcnt_r <= '0;
      end
      nsq_pkg::OP_DIV_STEP: begin
        if (!trial[NW+1]) begin
          rem_r <= trial[NW-1:0];
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= shifted[NW-1:0];
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 1'b1;
      end
      nsq_pkg::OP_UPDATE: begin
        guess_r <= guess_nxt;
        conv_r  <= (nsq_pkg::CMP_W'(diff) < nsq_pkg::CMP_W'(tol_r));
        iter_r  <= iter_r + 1'b1;
      end
      nsq_pkg::OP_SET_HIT: begin
        hit_r <= 1'b1;
      end
      nsq_pkg::OP_PUBLISH: begin
        if (publish) begin
          out_root_r    <= root_nxt;
          out_invalid_r <= neg_r;
          out_hit_r     <= hit_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.root      = out_root_r;
  assign out_ch.invalid   = out_invalid_r;
  assign out_ch.hit_limit = out_hit_r;

endmodule
`default_nettype wire

// File: src/nsq_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jump logic.
`default_nettype none
module nsq_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire nsq_pkg::status_t status,
  output nsq_pkg::ctrl_t        ctrl
);

  nsq_pkg::pc_t pc_r;
  nsq_pkg::pc_t pc_nxt;
  logic         take;

  assign ctrl = nsq_pkg::rom_word(pc_r);

  always_comb begin
    case (ctrl.cnd)
      nsq_pkg::C_NEVER:     take = 1'b0;
      nsq_pkg::C_ALWAYS:    take = 1'b1;
      nsq_pkg::C_NOT_FIRE:  take = !status.in_fire;
      nsq_pkg::C_TRIVIAL:   take = status.trivial;
      nsq_pkg::C_GZERO:     take = status.gzero;
      nsq_pkg::C_DIV_MORE:  take = status.div_more;
      nsq_pkg::C_CONV:      take = status.conv;
      nsq_pkg::C_ITER_LEFT: take = status.iter_left;
      nsq_pkg::C_OUT_BUSY:  take = status.out_busy;
      default:              take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.target : nsq_pkg::pc_t'(pc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= nsq_pkg::S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/nsq_checker.sv
// Port-level assertions for the Newton square root block and their bind to the top level.
`default_nettype none
module nsq_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [nsq_pkg::ROOT_W-1:0]  out_root,
  input wire logic                        out_invalid,
  input wire logic                        out_hit_limit
);

  // The block is busy on the cycle after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // A negative input yields a zero root and no iteration flag.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_root == '0) && !out_hit_limit)
    else $error("invalid result with nonzero root or limit flag");

  // An empty output stays empty on the cycle right after an input transaction.
  a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared one cycle after an accept");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_root) && $stable(out_invalid) && $stable(out_hit_limit)))
    else $error("result payload changed while stalled");

endmodule

bind newton_square_root nsq_checker u_nsq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_root      (out_ch.root),
  .out_invalid   (out_ch.invalid),
  .out_hit_limit (out_ch.hit_limit)
);
`default_nettype wire
